/* rtl/core/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// Group-by sum table package
// Shared widths, codes and the structs that pass between cells.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned CapacityDef = 64;

  typedef enum logic {
    OP_ACCUMULATE = 1'b0,
    OP_DRAIN      = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_UPDATED = 2'd0,
    STATUS_NEW     = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_DRAIN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  // One table entry held by a cell
  typedef struct packed {
    logic             used;
    logic [DataW-1:0] key;
    logic [DataW-1:0] sum;
  } entry_t;

  // Accumulate transaction travelling down the chain; value carries the
  // addend until a cell resolves it, then the resulting sum
  typedef struct packed {
    logic             vld;
    logic             done;
    status_e          status;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } probe_t;

endpackage

/* rtl/core/group_by_sum_table.sv */
// ----------------------------------------------------------------------------
// Group-by sum table
// Port       Dir  Handshake              Carries
// start_i    in   start_i & !busy_o      operation, group key, addend
// result_*   out  result_valid_o strobe  status, entry valid, key, sum, last
//
// Accumulates run down a chain of CAPACITY cells, one cell a cycle, and
// pipeline: one may be accepted every cycle while busy_o is low; its result
// leaves the last cell through the output register. A drain waits for the
// chain to empty, then shifts the entries out of cell 0, one result a cycle,
// busy throughout. Reset clears the entry flags and control; no clearing
// pass. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module group_by_sum_table #(
  parameter int unsigned CAPACITY = gbs_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic signed [gbs_pkg::DataW-1:0] group_key_i,
  input  logic signed [gbs_pkg::DataW-1:0] addend_i,
  output logic                        result_valid_o,
  output logic [1:0]                  status_o,
  output logic                        entry_valid_o,
  output logic signed [gbs_pkg::DataW-1:0] out_key_o,
  output logic signed [gbs_pkg::DataW-1:0] out_sum_o,
  output logic                        last_o
);

  gbs_pkg::state_e state_d, state_q;
  gbs_pkg::probe_t prb_in;
  gbs_pkg::probe_t prb [CAPACITY+1];
  gbs_pkg::entry_t ent [CAPACITY+1];
  logic            accept;
  logic            shift;
  logic            chain_busy;

  logic                     res_vld_d, res_vld_q;
  gbs_pkg::status_e         res_status_d, res_status_q;
  logic                     res_ent_vld_d, res_ent_vld_q;
  logic [gbs_pkg::DataW-1:0] res_key_d, res_key_q;
  logic [gbs_pkg::DataW-1:0] res_sum_d, res_sum_q;
  logic                     res_last_d, res_last_q;

  assign accept = start_i && !busy_o;

  always_comb begin
    prb_in        = '0;
    prb_in.vld    = accept && (gbs_pkg::op_e'(operation_i) == gbs_pkg::OP_ACCUMULATE);
    prb_in.status = gbs_pkg::STATUS_FULL;
    prb_in.key    = group_key_i;
    prb_in.value  = addend_i;
  end

  assign prb[0]        = prb_in;
  assign ent[CAPACITY] = '0;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    gbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .prb_i     (prb[j]),
      .prb_o     (prb[j+1]),
      .shift_i   (shift),
      .ent_nxt_i (ent[j+1]),
      .ent_o     (ent[j])
    );
  end

  always_comb begin
    chain_busy = 1'b0;
    for (int j = 1; j <= CAPACITY; j++) begin
      chain_busy = chain_busy | prb[j].vld;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbs_pkg::ST_IDLE: begin
        if (accept && (gbs_pkg::op_e'(operation_i) == gbs_pkg::OP_DRAIN)) begin
          state_d = gbs_pkg::ST_FLUSH;
        end
      end
      gbs_pkg::ST_FLUSH: begin
        if (!chain_busy) begin
          state_d = gbs_pkg::ST_DRAIN;
        end
      end
      gbs_pkg::ST_DRAIN: begin
        if (!ent[0].used || !ent[1].used) begin
          state_d = gbs_pkg::ST_IDLE;
        end
      end
      default: state_d = gbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o = (state_q != gbs_pkg::ST_IDLE);
    shift  = (state_q == gbs_pkg::ST_DRAIN);
  end

  always_comb begin
    res_vld_d     = 1'b0;
    res_status_d  = prb[CAPACITY].status;
    res_ent_vld_d = 1'b0;
    res_key_d     = prb[CAPACITY].key;
    res_sum_d     = prb[CAPACITY].done ? prb[CAPACITY].value : '0;
    res_last_d    = 1'b1;
    if (shift) begin
      res_vld_d     = 1'b1;
      res_status_d  = gbs_pkg::STATUS_DRAIN;
      res_ent_vld_d = ent[0].used;
      res_key_d     = ent[0].used ? ent[0].key : '0;
      res_sum_d     = ent[0].used ? ent[0].sum : '0;
      res_last_d    = !ent[0].used || !ent[1].used;
    end else if (prb[CAPACITY].vld) begin
      res_vld_d    = 1'b1;
      res_status_d = prb[CAPACITY].done ? prb[CAPACITY].status : gbs_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gbs_pkg::ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q  <= res_status_d;
    res_ent_vld_q <= res_ent_vld_d;
    res_key_q     <= res_key_d;
    res_sum_q     <= res_sum_d;
    res_last_q    <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign entry_valid_o  = res_ent_vld_q;
  assign out_key_o      = res_key_q;
  assign out_sum_o      = res_sum_q;
  assign last_o         = res_last_q;

  // no accumulate may leave the chain while entries are shifted out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbs_pkg::ST_DRAIN) |-> !prb[CAPACITY].vld)
    else $error("accumulate transaction in chain during drain");

  // cell 1 holds an entry only if cell 0 does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent[1].used |-> ent[0].used)
    else $error("gap in used entries");

  // an accepted accumulate enters cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prb[0].vld |=> prb[1].vld)
    else $error("accumulate transaction lost at cell 0");

  // every drain cycle yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbs_pkg::ST_DRAIN) |=> result_valid_o)
    else $error("drain cycle without result");

endmodule

/* rtl/core/gbs_cell.sv */
// ----------------------------------------------------------------------------
// Group-by sum table cell
// Holds one entry, resolves a passing accumulate, shifts on drain.
// ----------------------------------------------------------------------------
module gbs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gbs_pkg::probe_t prb_i,
  output gbs_pkg::probe_t prb_o,
  input  logic            shift_i,
  input  gbs_pkg::entry_t ent_nxt_i,
  output gbs_pkg::entry_t ent_o
);

  gbs_pkg::entry_t ent_d, ent_q;
  gbs_pkg::probe_t prb_d, prb_q;
  logic [gbs_pkg::DataW-1:0] sum_add;

  assign sum_add = ent_q.sum + prb_i.value;

  always_comb begin
    ent_d = ent_q;
    prb_d = prb_i;
    if (shift_i) begin
      ent_d = ent_nxt_i;
    end else if (prb_i.vld && !prb_i.done) begin
      if (ent_q.used && (ent_q.key == prb_i.key)) begin
        ent_d.sum    = sum_add;
        prb_d.done   = 1'b1;
        prb_d.status = gbs_pkg::STATUS_UPDATED;
        prb_d.value  = sum_add;
      end else if (!ent_q.used) begin
        ent_d.used   = 1'b1;
        ent_d.key    = prb_i.key;
        ent_d.sum    = prb_i.value;
        prb_d.done   = 1'b1;
        prb_d.status = gbs_pkg::STATUS_NEW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      prb_q <= '0;
    end else begin
      ent_q <= ent_d;
      prb_q <= prb_d;
    end
  end

  assign prb_o = prb_q;
  assign ent_o = ent_q;

endmodule

/* tb/group_by_sum_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group-by sum table testbench
// Drives accumulate and drain transactions through the start/busy handshake,
// predicts every strobed result with a behavioural copy of the table, and
// compares each one field by field in arrival order. A short directed table
// covers the extremes, wrap-around, empty drains and ignored drain fields.
// Random rounds follow with small, medium and oversized key pools so that
// the table also overflows.
// ----------------------------------------------------------------------------
module group_by_sum_table_tb;
  import gbs_pkg::*;

  localparam int unsigned Capacity   = CapacityDef;
  localparam int          ItemTarget = 470;
  localparam logic [63:0] MinS   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxS   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegOne = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegTwo = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] Alt5   = 64'h5555_5555_5555_5555;
  localparam logic [63:0] AltA   = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    status_e     status;
    logic        valid;
    logic [63:0] key;
    logic [63:0] sum;
    logic        last;
  } group_result_t;

  typedef struct packed {
    op_e           op;
    logic [63:0]   key;
    logic [63:0]   addend;
    logic          typed;
    group_result_t exp;
  } stim_row_t;

  localparam int NumRows = 16;
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{OP_DRAIN,      64'd0, 64'd0,  1'b1, '{STATUS_DRAIN,   1'b0, 64'd0, 64'd0, 1'b1}},
    '{OP_ACCUMULATE, MinS,  MaxS,   1'b1, '{STATUS_NEW,     1'b0, MinS,  MaxS,  1'b1}},
    '{OP_ACCUMULATE, MinS,  64'd1,  1'b1, '{STATUS_UPDATED, 1'b0, MinS,  MinS,  1'b1}},
    '{OP_ACCUMULATE, MaxS,  MinS,   1'b1, '{STATUS_NEW,     1'b0, MaxS,  MinS,  1'b1}},
    '{OP_ACCUMULATE, MaxS,  NegOne, 1'b1, '{STATUS_UPDATED, 1'b0, MaxS,  MaxS,  1'b1}},
    '{OP_ACCUMULATE, 64'd0, 64'd0,  1'b1, '{STATUS_NEW,     1'b0, 64'd0, 64'd0, 1'b1}},
    '{OP_ACCUMULATE, NegOne, NegOne, 1'b1, '{STATUS_NEW,    1'b0, NegOne, NegOne, 1'b1}},
    '{OP_ACCUMULATE, NegOne, NegOne, 1'b1, '{STATUS_UPDATED, 1'b0, NegOne, NegTwo, 1'b1}},
    '{OP_ACCUMULATE, Alt5,  AltA,   1'b0, '0},
    '{OP_ACCUMULATE, AltA,  Alt5,   1'b0, '0},
    '{OP_ACCUMULATE, Alt5,  Alt5,   1'b0, '0},
    '{OP_DRAIN,      AltA,  NegOne, 1'b0, '0},
    '{OP_DRAIN,      MaxS,  MaxS,   1'b1, '{STATUS_DRAIN,   1'b0, 64'd0, 64'd0, 1'b1}},
    '{OP_ACCUMULATE, 64'd1, MinS,   1'b1, '{STATUS_NEW,     1'b0, 64'd1, MinS,  1'b1}},
    '{OP_ACCUMULATE, 64'd1, MinS,   1'b1, '{STATUS_UPDATED, 1'b0, 64'd1, 64'd0, 1'b1}},
    '{OP_DRAIN,      NegOne, Alt5,  1'b0, '0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic        operation_i = 1'b0;
  logic signed [DataW-1:0] group_key_i = '0;
  logic signed [DataW-1:0] addend_i    = '0;
  logic        busy_o;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic        entry_valid_o;
  logic signed [DataW-1:0] out_key_o;
  logic signed [DataW-1:0] out_sum_o;
  logic        last_o;

  group_by_sum_table #(.CAPACITY(Capacity)) dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .operation_i,
    .group_key_i,
    .addend_i,
    .result_valid_o,
    .status_o,
    .entry_valid_o,
    .out_key_o,
    .out_sum_o,
    .last_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow table
  logic [63:0]   grp_key  [Capacity];
  logic [63:0]   grp_sum  [Capacity];
  logic          grp_used [Capacity];
  group_result_t results_due [$];
  int            errors     = 0;
  int            items_sent = 0;
  bit            calm       = 1'b0;

  function automatic void queue_due(input group_result_t r);
    results_due.insert(results_due.size(), r);
  endfunction

  function automatic void fold_into_groups(op_e op, logic [63:0] k, logic [63:0] a);
    int hit;
    int free_slot;
    int tail;
    group_result_t r;
    hit = -1;
    free_slot = -1;
    tail = -1;
    if (op == OP_ACCUMULATE) begin
      for (int i = 0; i < Capacity; i++) begin
        if (grp_used[i] && grp_key[i] == k && hit < 0) hit = i;
        if (!grp_used[i] && free_slot < 0) free_slot = i;
      end
      r.valid = 1'b0;
      r.key   = k;
      r.last  = 1'b1;
      if (hit >= 0) begin
        grp_sum[hit] = grp_sum[hit] + a;
        r.status = STATUS_UPDATED;
        r.sum    = grp_sum[hit];
      end else if (free_slot < 0) begin
        r.status = STATUS_FULL;
        r.sum    = '0;
      end else begin
        grp_used[free_slot] = 1'b1;
        grp_key[free_slot]  = k;
        grp_sum[free_slot]  = a;
        r.status = STATUS_NEW;
        r.sum    = a;
      end
      queue_due(r);
    end else begin
      for (int i = 0; i < Capacity; i++)
        if (grp_used[i]) tail = i;
      if (tail < 0) begin
        queue_due('{STATUS_DRAIN, 1'b0, 64'd0, 64'd0, 1'b1});
      end else begin
        for (int i = 0; i < Capacity; i++) begin
          if (grp_used[i])
            queue_due('{STATUS_DRAIN, 1'b1, grp_key[i], grp_sum[i], i == tail});
          grp_used[i] = 1'b0;
        end
      end
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_addend();
    logic signed [63:0] v;
    int s;
    case ($urandom_range(0, 7))
      0, 1: begin
        s = int'($urandom_range(0, 16)) - 8;
        v = 64'(s);
      end
      2: v = $urandom_range(0, 1) ? MinS : MaxS;
      default: v = rand64();
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 15))
      0: return MinS;
      1: return MaxS;
      2: return NegOne;
      3: return 64'd0;
      default: return rand64();
    endcase
  endfunction

  task automatic issue(input op_e op, input logic [63:0] k, input logic [63:0] a,
                       input logic typed, input group_result_t exp);
    start_i     <= 1'b1;
    operation_i <= op;
    group_key_i <= k;
    addend_i    <= a;
    do @(posedge clk_i); while (busy_o);
    fold_into_groups(op, k, a);
    if (typed) begin
      void'(results_due.pop_back());
      queue_due(exp);
    end
    items_sent++;
  endtask

  task automatic maybe_idle();
    if (!calm && items_sent < ItemTarget - 60 && $urandom_range(0, 7) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Hold off until every outstanding result has arrived
  task automatic wait_settled();
    if (results_due.size() != 0) begin
      start_i <= 1'b0;
      while (results_due.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp,
                             input logic [63:0] got);
    if (exp !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, got);
    end
  endtask

  always @(posedge clk_i) begin
    group_result_t e;
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d key %h sum %h",
                 $time, status_o, out_key_o, out_sum_o);
      end else begin
        e = results_due.pop_front();
        check_field("status", 64'(e.status), 64'(status_o));
        check_field("entry_valid", 64'(e.valid), 64'(entry_valid_o));
        check_field("out_key", e.key, out_key_o);
        check_field("out_sum", e.sum, out_sum_o);
        check_field("last", 64'(e.last), 64'(last_o));
      end
    end
  end

  initial begin
    logic [63:0] key_pool [$];
    int mode;
    int pool_n;
    int len;
    int round;
    logic [63:0] k;
    round = 0;
    for (int i = 0; i < Capacity; i++) grp_used[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      maybe_idle();
      issue(DirectedRows[r].op, DirectedRows[r].key, DirectedRows[r].addend,
            DirectedRows[r].typed, DirectedRows[r].exp);
    end
    wait_settled();

    while (items_sent < ItemTarget) begin
      mode = (round == 0) ? 2 : $urandom_range(0, 2);
      case (mode)
        0:       pool_n = $urandom_range(1, 6);
        1:       pool_n = $urandom_range(8, 48);
        default: pool_n = $urandom_range(Capacity + 1, Capacity + 20);
      endcase
      len = (mode == 2) ? pool_n + $urandom_range(5, 30) : $urandom_range(10, 60);
      key_pool.delete();
      repeat (pool_n) key_pool.push_front(rand_key());
      calm = ($urandom_range(0, 3) == 0) || (items_sent > ItemTarget - 60);
      for (int n = 0; n < len && items_sent < ItemTarget; n++) begin
        maybe_idle();
        if (round > 0 && $urandom_range(0, 29) == 0) begin
          issue(OP_DRAIN, rand64(), rand64(), 1'b0, '0);
        end else begin
          k = (mode == 2 && n < pool_n) ? key_pool[n] : key_pool[$urandom_range(0, pool_n - 1)];
          issue(OP_ACCUMULATE, k, rand_addend(), 1'b0, '0);
        end
      end
      if (!calm && items_sent < ItemTarget - 60 && $urandom_range(0, 3) == 0) wait_settled();
      maybe_idle();
      issue(OP_DRAIN, rand64(), rand64(), 1'b0, '0);
      round++;
    end

    start_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2 * Capacity + 8) @(posedge clk_i);
    if (errors == 0 && results_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gbs_pkg.sv
rtl/core/gbs_cell.sv
rtl/core/group_by_sum_table.sv
tb/group_by_sum_table_tb.sv
